// ===== sv/aktf_pkg.sv =====
`timescale 1ns / 1ps

package aktf_pkg;

	// Width of one travel sample and of the signed sample-to-sample difference.
	localparam int SAMPLE_W = 12;
	localparam int DIFF_W   = SAMPLE_W + 1;

	// Travel scale. Zero means fully up.
	localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = '0;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'd4095;

	// Speed mode releases when travel falls faster than this per sample.
	localparam logic signed [DIFF_W-1:0] LIFT_SPEED = 13'sd64;

	typedef enum logic [1:0] {
		MODE_DIGITAL = 2'd0,
		MODE_NORMAL  = 2'd1,
		MODE_RAPID   = 2'd2,
		MODE_SPEED   = 2'd3
	} key_mode_t;

	typedef enum logic [2:0] {
		REG_KEY_MODE        = 3'd0,
		REG_ACTIVATION      = 3'd1,
		REG_DEACTIVATION    = 3'd2,
		REG_TOP_DEADZONE    = 3'd3,
		REG_BOTTOM_DEADZONE = 3'd4,
		REG_PRESS_DISTANCE  = 3'd5,
		REG_LIFT_DISTANCE   = 3'd6,
		REG_PRESS_SPEED     = 3'd7
	} reg_index_t;

	typedef struct packed {
		key_mode_t                  key_mode;
		logic [SAMPLE_W-1:0]        activation_level;
		logic [SAMPLE_W-1:0]        deactivation_level;
		logic [SAMPLE_W-1:0]        top_deadzone;
		logic [SAMPLE_W-1:0]        bottom_deadzone;
		logic [SAMPLE_W-1:0]        press_distance;
		logic [SAMPLE_W-1:0]        lift_distance;
		logic signed [DIFF_W-1:0]   press_speed;
	} key_cfg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] last_sample;
		logic [SAMPLE_W-1:0] extremum;
		logic                key_down;
	} key_state_t;

	localparam key_cfg_t CFG_RESET = '{
		key_mode:           MODE_NORMAL,
		activation_level:   12'd2048,
		deactivation_level: 12'd1536,
		top_deadzone:       12'd0,
		bottom_deadzone:    12'd0,
		press_distance:     12'd128,
		lift_distance:      12'd128,
		press_speed:        13'sd64
	};

endpackage

// ===== sv/aktf_decide.sv =====
`timescale 1ns / 1ps

// Decision logic for one sample: next key state, new tracked extremum and the change flag.
module aktf_decide
	import aktf_pkg::*;
(
	input  key_cfg_t            cfg,
	input  key_state_t          cur,
	input  logic [SAMPLE_W-1:0] sample,
	output key_state_t          nxt,
	output logic                changed
);

	logic signed [DIFF_W-1:0] diff;
	logic signed [DIFF_W-1:0] neg_diff;
	logic                     top_hit;
	logic                     bottom_hit;
	logic                     lift_hit;
	logic                     press_hit;
	logic                     now;

	assign diff     = $signed({1'b0, sample}) - $signed({1'b0, cur.last_sample});
	assign neg_diff = -diff;

	// Offsets from fully up; SAMPLE_MIN is zero, so the subtraction is exact.
	assign top_hit    = (sample - SAMPLE_MIN) <= cfg.top_deadzone;
	assign bottom_hit = ({1'b0, sample} + {1'b0, cfg.bottom_deadzone}) >= {1'b0, SAMPLE_MAX};
	assign lift_hit   = {1'b0, cur.extremum} >= ({1'b0, sample} + {1'b0, cfg.lift_distance});
	assign press_hit  = {1'b0, sample} >= ({1'b0, cur.extremum} + {1'b0, cfg.press_distance});

	always_comb begin
		nxt             = cur;
		nxt.last_sample = sample;
		now             = cur.key_down;
		unique case (cfg.key_mode)
			MODE_DIGITAL: begin
				now = (sample != '0);
			end
			MODE_NORMAL: begin
				if ((sample - SAMPLE_MIN) > cfg.activation_level) begin
					now = 1'b1;
				end else if ((sample - SAMPLE_MIN) < cfg.deactivation_level) begin
					now = 1'b0;
				end
			end
			MODE_RAPID: begin
				if (top_hit) begin
					now = 1'b0;
					if (sample < cur.extremum) nxt.extremum = sample;
				end else if (bottom_hit) begin
					now = 1'b1;
					if (sample > cur.extremum) nxt.extremum = sample;
				end else if (cur.key_down) begin
					// Pressed: release on lift back from the peak, else follow the peak.
					if (lift_hit) begin
						now          = 1'b0;
						nxt.extremum = sample;
					end else if (sample > cur.extremum) begin
						nxt.extremum = sample;
					end
				end else begin
					// Released: press on travel past the trough, else follow the trough.
					if (press_hit) begin
						now          = 1'b1;
						nxt.extremum = sample;
					end else if (sample < cur.extremum) begin
						nxt.extremum = sample;
					end
				end
			end
			MODE_SPEED: begin
				if (diff > cfg.press_speed) now = 1'b1;
				if (neg_diff > LIFT_SPEED) now = 1'b0;
				if (top_hit) now = 1'b0;
				if (bottom_hit) now = 1'b1;
			end
		endcase
		nxt.key_down = now;
		changed      = now ^ cur.key_down;
	end

endmodule

// ===== sv/analog_key_trigger_fsm.sv =====
`timescale 1ns / 1ps

// Trigger logic for an analog (hall effect) key. Each slave-side transaction carries one
// normalised travel sample and yields exactly one master-side transaction with the new
// pressed state and a flag that is set when that state differs from the previous one.
// Four modes are selected by key_mode: digital (pressed when travel is nonzero), normal
// hysteresis between the activation and deactivation levels, rapid trigger (deadzones at
// both ends of travel plus press and lift distances measured from a tracked extremum) and
// speed (thresholds on the sample-to-sample difference, with the deadzones taking
// precedence). Throughput is one sample per clock cycle while m_tready is not held low: a sample
// is registered on entry, then a single compare-and-update step produces the result and the
// new key state together, and both are registered when the result register can move on.
// The key state is one register loop closed in that single step. Configuration registers
// should only be written while no sample is in flight.
module analog_key_trigger_fsm
	import aktf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	// Configuration write port.
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data,

	// Sample input.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,     // [11:0] travel_sample, [15:12] zero

	// Result output.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata      // [0] pressed, [1] changed, [7:2] zero
);

	key_cfg_t            cfg_q;
	key_state_t          state_q;
	key_state_t          state_nxt;

	logic                valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;

	logic                out_valid_q;
	logic                out_pressed_q;
	logic                out_changed_q;
	logic                changed_nxt;

	logic                advance;
	logic                load_out;

	// Configuration registers. Every index of the port maps onto a register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr_en) begin
			unique case (reg_index_t'(cfg_index))
				REG_KEY_MODE:        cfg_q.key_mode           <= key_mode_t'(cfg_data[1:0]);
				REG_ACTIVATION:      cfg_q.activation_level   <= cfg_data[SAMPLE_W-1:0];
				REG_DEACTIVATION:    cfg_q.deactivation_level <= cfg_data[SAMPLE_W-1:0];
				REG_TOP_DEADZONE:    cfg_q.top_deadzone       <= cfg_data[SAMPLE_W-1:0];
				REG_BOTTOM_DEADZONE: cfg_q.bottom_deadzone    <= cfg_data[SAMPLE_W-1:0];
				REG_PRESS_DISTANCE:  cfg_q.press_distance     <= cfg_data[SAMPLE_W-1:0];
				REG_LIFT_DISTANCE:   cfg_q.lift_distance      <= cfg_data[SAMPLE_W-1:0];
				REG_PRESS_SPEED:     cfg_q.press_speed        <= $signed(cfg_data[DIFF_W-1:0]);
			endcase
		end
	end

	// The result register moves on when it is empty or its contents are being taken.
	// The input stage moves on with it, so a sample can enter in every cycle while the
	// result side keeps up, and one more is held while the result side is stalled.
	assign advance  = !out_valid_q || m_tready;
	assign load_out = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			sample_s1 <= s_tdata[SAMPLE_W-1:0];
		end
	end

	aktf_decide u_decide (
		.cfg     (cfg_q),
		.cur     (state_q),
		.sample  (sample_s1),
		.nxt     (state_nxt),
		.changed (changed_nxt)
	);

	// Key state is committed in the same cycle the result is written, so the next
	// sample always sees the state left by the one before it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_pressed_q <= state_nxt.key_down;
			out_changed_q <= changed_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_changed_q, out_pressed_q};

	// The changed flag reports a difference from the state held before the sample.
	assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (out_changed_q == (out_pressed_q ^ $past(state_q.key_down))))
		else $error("changed flag does not match previous key state");

	// A waiting result always agrees with the committed key state.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (state_q.key_down == out_pressed_q))
		else $error("result pressed bit and key state disagree");

	// Digital mode presses exactly when travel is nonzero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && (cfg_q.key_mode == MODE_DIGITAL))
		|=> (out_pressed_q == ($past(sample_s1) != '0)))
		else $error("digital mode decision wrong");

	// A sample waiting in the input stage is neither lost nor overwritten.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(sample_s1)))
		else $error("input stage lost a sample");

	// Back-pressure towards the source only arises from a full input stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1)
		else $error("input stalled with an empty stage");

endmodule

// ===== tb/analog_key_trigger_fsm_test.sv =====
`timescale 1ns / 1ps

module analog_key_trigger_fsm_test;
	import aktf_pkg::*;

	// The run stops here whatever happens. It is several times the slowest
	// correct run: every sample meeting the longest sender gap and the
	// longest receiver stall.
	localparam int CYCLE_LIMIT   = 250000;
	// Cycles allowed after the last result before a register write or the
	// verdict.
	localparam int SETTLE_CYCLES = 6;
	localparam int RANDOM_PHASES = 13;
	localparam int PHASE_SAMPLES = 150;

	// One result transaction as it appears on m_tdata.
	typedef struct packed {
		logic changed;
		logic pressed;
	} key_result_t;

	// Rows of the directed table. A known row carries a result that can be
	// read straight off the mode rules; a plain sample row is checked
	// against the key tracker below.
	typedef enum logic [1:0] {
		ROW_WRITE,
		ROW_SAMPLE,
		ROW_KNOWN
	} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		reg_index_t  index;
		logic [12:0] value;
		logic [11:0] sample;
		key_result_t result;
	} stim_row_t;

	// Receiver behaviour, switched now and then so that stalls land on
	// every phase of the block's work, with stretches of no stall at all.
	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_COIN,
		READY_SPARSE,
		READY_BURSTY
	} ready_style_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [2:0]  cfg_index;
	logic [12:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;    // [11:0] travel_sample, [15:12] zero
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;    // [0] pressed, [1] changed, [7:2] zero

	// Our own copy of the configuration, updated whenever a register is
	// written, and of the key state that the block keeps.
	key_mode_t          mode_setting;
	logic [11:0]        activation_setting;
	logic [11:0]        deactivation_setting;
	logic [11:0]        top_zone_setting;
	logic [11:0]        bottom_zone_setting;
	logic [11:0]        press_dist_setting;
	logic [11:0]        lift_dist_setting;
	logic signed [12:0] speed_setting;

	logic [11:0] tracked_last;
	logic [11:0] tracked_extremum;
	logic        tracked_down;

	key_result_t  expected_keys[$];
	stim_row_t    stim_rows[$];
	int           fail_count  = 0;
	int           cycle_count = 0;
	int           burst_left  = 0;
	int           walk_pos    = 0;
	ready_style_t ready_style = READY_ALWAYS;
	int           style_left  = 0;
	int           stall_hold  = 0;

	analog_key_trigger_fsm dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog. Reaching the limit means that results have stopped coming.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $realtime,
				expected_keys.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// Works out the key decision for one accepted sample and moves the
	// tracked state on. The arithmetic is done in int so that the deadzone
	// edge and the signed difference cannot wrap.
	function automatic key_result_t track_key(input logic [11:0] sample);
		int          v;
		int          diff;
		int          ext;
		int          bottom_edge;
		logic        now;
		key_result_t res;
		v           = int'(sample);
		diff        = v - int'(tracked_last);
		ext         = int'(tracked_extremum);
		now         = tracked_down;
		bottom_edge = int'(SAMPLE_MAX) - int'(bottom_zone_setting);
		tracked_last = sample;
		case (mode_setting)
			MODE_DIGITAL: begin
				now = (v != 0);
			end
			MODE_NORMAL: begin
				// Activation is tested first; between the levels the key holds.
				if (v > int'(activation_setting))
					now = 1'b1;
				else if (v < int'(deactivation_setting))
					now = 1'b0;
			end
			MODE_RAPID: begin
				// The deadzones win outright and only push the extremum outward.
				if (v <= int'(top_zone_setting)) begin
					if (v < ext)
						ext = v;
					now = 1'b0;
				end else if (v >= bottom_edge) begin
					if (v > ext)
						ext = v;
					now = 1'b1;
				end else begin
					if (tracked_down && ext - v >= int'(lift_dist_setting)) begin
						now = 1'b0;
						ext = v;
					end
					if (!tracked_down && v - ext >= int'(press_dist_setting)) begin
						now = 1'b1;
						ext = v;
					end
					// Tracking is judged on the state before this sample.
					if ((tracked_down && v > ext) || (!tracked_down && v < ext))
						ext = v;
				end
			end
			default: begin
				// Speed mode: later tests override earlier ones, so the bottom
				// deadzone has the last word when the two zones overlap.
				if (diff > int'(speed_setting))
					now = 1'b1;
				if (-diff > int'(LIFT_SPEED))
					now = 1'b0;
				if (v <= int'(top_zone_setting))
					now = 1'b0;
				if (v >= bottom_edge)
					now = 1'b1;
			end
		endcase
		tracked_extremum = 12'(ext);
		res.pressed  = now;
		res.changed  = (now != tracked_down);
		tracked_down = now;
		return res;
	endfunction

	function automatic void mirror_register(input reg_index_t index,
			input logic [12:0] value);
		case (index)
			REG_KEY_MODE:        mode_setting         = key_mode_t'(value[1:0]);
			REG_ACTIVATION:      activation_setting   = value[11:0];
			REG_DEACTIVATION:    deactivation_setting = value[11:0];
			REG_TOP_DEADZONE:    top_zone_setting     = value[11:0];
			REG_BOTTOM_DEADZONE: bottom_zone_setting  = value[11:0];
			REG_PRESS_DISTANCE:  press_dist_setting   = value[11:0];
			REG_LIFT_DISTANCE:   lift_dist_setting    = value[11:0];
			default:             speed_setting        = value;
		endcase
	endfunction

	function automatic logic next_ready();
		logic rdy;
		if (style_left == 0) begin
			ready_style = ready_style_t'($urandom_range(0, 3));
			style_left  = $urandom_range(20, 200);
		end
		style_left--;
		case (ready_style)
			READY_ALWAYS: rdy = 1'b1;
			READY_COIN:   rdy = 1'($urandom_range(0, 1));
			READY_SPARSE: rdy = ($urandom_range(0, 3) == 0);
			default: begin
				if (stall_hold > 0) begin
					stall_hold--;
					rdy = 1'b0;
				end else if ($urandom_range(0, 9) == 0) begin
					stall_hold = $urandom_range(1, 12);
					rdy = 1'b0;
				end else begin
					rdy = 1'b1;
				end
			end
		endcase
		return rdy;
	endfunction

	// Result side: each accepted transaction is compared with the oldest
	// expected key state, then the receiver decides whether to stall.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_keys.size() == 0) begin
					$display("%0t: unexpected result, actual pressed %0b changed %0b",
						$realtime, m_tdata[0], m_tdata[1]);
					fail_count++;
				end else begin
					automatic key_result_t want = expected_keys.pop_front();
					if (m_tdata[0] !== want.pressed) begin
						$display("%0t: pressed mismatch, expected %0b actual %0b",
							$realtime, want.pressed, m_tdata[0]);
						fail_count++;
					end
					if (m_tdata[1] !== want.changed) begin
						$display("%0t: changed mismatch, expected %0b actual %0b",
							$realtime, want.changed, m_tdata[1]);
						fail_count++;
					end
				end
			end
			m_tready <= next_ready();
		end
	end

	// Offers one sample and waits for its transaction. The sender works in
	// bursts: when a burst runs out, valid may drop for a random gap. Valid
	// is left high on return so that back-to-back samples need no new edge.
	task automatic send_sample(input logic [11:0] sample, input bit known,
			input key_result_t known_result);
		int          gap;
		key_result_t res;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0000, sample};
		do
			@(posedge clk);
		while (!s_tready);
		// The tracker always runs so that its state stays in step with the
		// block, even where the row gives the result itself.
		res = track_key(sample);
		expected_keys.push_back(known ? known_result : res);
	endtask

	// Brings the block to rest: no sample offered, every result received,
	// and the pipeline given time to drain.
	task automatic settle();
		s_tvalid   <= 1'b0;
		burst_left = 0;
		while (expected_keys.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The enable is dropped after each write and the task waits once more, so
	// that two writes in a row never assign it twice in one time step.
	task automatic write_reg(input reg_index_t index, input logic [12:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		mirror_register(index, value);
		@(posedge clk);
	endtask

	function automatic void add_write(input reg_index_t index, input logic [12:0] value);
		stim_row_t row;
		row.kind   = ROW_WRITE;
		row.index  = index;
		row.value  = value;
		row.sample = '0;
		row.result = '0;
		stim_rows.push_back(row);
	endfunction

	function automatic void add_sample(input logic [11:0] sample);
		stim_row_t row;
		row.kind   = ROW_SAMPLE;
		row.index  = REG_KEY_MODE;
		row.value  = '0;
		row.sample = sample;
		row.result = '0;
		stim_rows.push_back(row);
	endfunction

	function automatic void add_known(input logic [11:0] sample, input logic pressed,
			input logic changed);
		stim_row_t row;
		row.kind           = ROW_KNOWN;
		row.index          = REG_KEY_MODE;
		row.value          = '0;
		row.sample         = sample;
		row.result.pressed = pressed;
		row.result.changed = changed;
		stim_rows.push_back(row);
	endfunction

	// Threshold levels: the two ends of travel now and then, anything otherwise.
	function automatic logic [12:0] pick_level();
		case ($urandom_range(0, 7))
			0:       return 13'd0;
			1:       return 13'd4095;
			default: return 13'($urandom_range(0, 4095));
		endcase
	endfunction

	// Deadzones and distances are mostly small so that the key really moves
	// between states; the extremes still turn up.
	function automatic logic [12:0] pick_margin();
		case ($urandom_range(0, 9))
			0:       return 13'd0;
			1:       return 13'd4095;
			2:       return 13'($urandom_range(0, 4095));
			default: return 13'($urandom_range(0, 300));
		endcase
	endfunction

	function automatic logic [12:0] pick_speed();
		case ($urandom_range(0, 7))
			0:       return 13'h1000;
			1:       return 13'h0fff;
			default: return 13'(int'($urandom_range(0, 600)) - 300);
		endcase
	endfunction

	// Travel mostly follows a random walk, as a real key stroke would, so
	// that the rapid trigger extremum and the speed thresholds are exercised.
	// Jumps and parking at either end of travel are mixed in.
	function automatic logic [11:0] next_travel();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			walk_pos += int'($urandom_range(0, 400)) - 200;
		else if (pick < 80)
			walk_pos = $urandom_range(0, 4095);
		else if (pick < 87)
			walk_pos = 0;
		else if (pick < 94)
			walk_pos = 4095;
		else if ($urandom_range(0, 1) == 1)
			walk_pos = $urandom_range(0, 63);
		else
			walk_pos = $urandom_range(4032, 4095);
		if (walk_pos < 0)
			walk_pos = 0;
		if (walk_pos > 4095)
			walk_pos = 4095;
		return 12'(walk_pos);
	endfunction

	initial begin
		arst_n    <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_KEY_MODE;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		m_tready  <= 1'b0;

		mode_setting         = CFG_RESET.key_mode;
		activation_setting   = CFG_RESET.activation_level;
		deactivation_setting = CFG_RESET.deactivation_level;
		top_zone_setting     = CFG_RESET.top_deadzone;
		bottom_zone_setting  = CFG_RESET.bottom_deadzone;
		press_dist_setting   = CFG_RESET.press_distance;
		lift_dist_setting    = CFG_RESET.lift_distance;
		speed_setting        = CFG_RESET.press_speed;
		tracked_last         = '0;
		tracked_extremum     = '0;
		tracked_down         = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Normal mode out of reset: above 2048 presses, below 1536 releases,
		// and the level itself sits in the hysteresis band.
		add_known(12'd0,    1'b0, 1'b0);
		add_known(12'd4095, 1'b1, 1'b1);
		add_known(12'd2048, 1'b1, 1'b0);
		add_known(12'd1535, 1'b0, 1'b1);
		// Digital mode: any nonzero travel counts as pressed.
		add_write(REG_KEY_MODE, 13'(MODE_DIGITAL));
		add_known(12'd0,    1'b0, 1'b0);
		add_known(12'd1,    1'b1, 1'b1);
		add_known(12'd4095, 1'b1, 1'b0);
		add_known(12'd0,    1'b0, 1'b1);
		// Rapid trigger: top deadzone, press on rise, tracking of a new
		// maximum, hold just short of the lift distance, release exactly on
		// it, and the bottom deadzone.
		add_write(REG_TOP_DEADZONE, 13'd100);
		add_write(REG_BOTTOM_DEADZONE, 13'd100);
		add_write(REG_KEY_MODE, 13'(MODE_RAPID));
		add_sample(12'd50);
		add_sample(12'd200);
		add_sample(12'd300);
		add_sample(12'd180);
		add_sample(12'd172);
		add_sample(12'd4000);
		// Both deadzones covering all of travel: the top one wins here.
		add_write(REG_TOP_DEADZONE, 13'd4095);
		add_write(REG_BOTTOM_DEADZONE, 13'd4095);
		add_known(12'd4095, 1'b0, 1'b1);
		// Speed mode: a fast rise presses, a fast fall releases, and samples at
		// either end of travel land in the deadzones.
		add_write(REG_TOP_DEADZONE, 13'd0);
		add_write(REG_BOTTOM_DEADZONE, 13'd0);
		add_write(REG_PRESS_SPEED, 13'd100);
		add_write(REG_KEY_MODE, 13'(MODE_SPEED));
		add_sample(12'd0);
		add_sample(12'd200);
		add_sample(12'd100);
		add_sample(12'd4095);
		add_sample(12'd2000);
		// Most negative press speed: any rise at all presses.
		add_write(REG_PRESS_SPEED, 13'h1000);
		add_sample(12'd2010);
		// Overlapping deadzones in speed mode: the bottom one wins.
		add_write(REG_TOP_DEADZONE, 13'd4095);
		add_write(REG_BOTTOM_DEADZONE, 13'd4095);
		add_sample(12'd3000);

		foreach (stim_rows[i]) begin
			if (stim_rows[i].kind == ROW_WRITE) begin
				settle();
				write_reg(stim_rows[i].index, stim_rows[i].value);
			end else begin
				send_sample(stim_rows[i].sample, stim_rows[i].kind == ROW_KNOWN,
					stim_rows[i].result);
			end
		end

		// Random phases. Every register is rewritten at the start of each
		// phase, and the mode steps through all four settings in turn.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			settle();
			write_reg(REG_KEY_MODE, 13'(key_mode_t'(phase % 4)));
			write_reg(REG_ACTIVATION, pick_level());
			write_reg(REG_DEACTIVATION, pick_level());
			write_reg(REG_TOP_DEADZONE, pick_margin());
			write_reg(REG_BOTTOM_DEADZONE, pick_margin());
			write_reg(REG_PRESS_DISTANCE, pick_margin());
			write_reg(REG_LIFT_DISTANCE, pick_margin());
			write_reg(REG_PRESS_SPEED, pick_speed());
			for (int n = 0; n < PHASE_SAMPLES; n++)
				send_sample(next_travel(), 1'b0, '0);
		end

		settle();
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
